// ===== src/fssa_pkg.sv =====
// Shared types and constants for the free slot stack allocator.
package fssa_pkg;

    localparam int SLOT_W   = 10;
    localparam int STATUS_W = 2;
    localparam int SLOT_CAP = 1024;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_REUSED  = 2'd0,
        ST_FRESH   = 2'd1,
        ST_FULL    = 2'd2,
        ST_IGNORED = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

endpackage

// ===== src/fssa_mem.sv =====
// Simple dual-port synchronous slot memory with registered read data.
module fssa_mem
    import fssa_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 12
)
(
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/free_slot_stack_allocator_core.sv =====
// Top level of the free slot stack allocator: control, stack registers and slot memory.
//
// Usage:
//   Request channel: drive kind and slot_to_free with start high; the request is
//   taken at a rising edge where start is high and busy is low. kind selects
//   allocate (pop the most recently freed slot, else the next fresh slot, else
//   full) or free (push slot_to_free if it is live and below the high-water mark,
//   else ignored).
//   Result channel: done is high for exactly one cycle with slot and status valid.
//   The receiver must take it in that cycle; it cannot hold results off.
// Timing:
//   A request is taken in S_IDLE, where its slot memory entry is read; it is
//   resolved and written back in S_EXEC, and its result shows on the registered
//   done, slot and status outputs. busy is high for that one resolve cycle, so a
//   new request is not taken while busy, set by the read-then-write of the single
//   slot memory port pair. Each memory entry holds the slot's freed mark and its link.
// Reset:
//   rst_n clears the stack (empty), the high-water count and the control state.
//   The slot memory is not cleared: every entry is written before its contents are used.
module free_slot_stack_allocator_core
    import fssa_pkg::*;
#(
    parameter int SLOT_COUNT = 1024
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                kind,
    input  logic [SLOT_W-1:0]   slot_to_free,
    output logic                done,
    output logic [SLOT_W-1:0]   slot,
    output logic [STATUS_W-1:0] status
);

    localparam int SLOT_LIMIT = (SLOT_COUNT < SLOT_CAP) ? SLOT_COUNT : SLOT_CAP;
    localparam int IDX_W      = $clog2(SLOT_LIMIT);
    localparam int HW_W       = $clog2(SLOT_LIMIT + 1);
    localparam int CMP_W      = SLOT_W + 1;
    // entry: {freed mark, end of list, next slot}
    localparam int ENTRY_W    = IDX_W + 2;

    state_t              state_reg, state_next;
    logic                kind_reg, kind_next;
    logic [SLOT_W-1:0]   req_reg, req_next;
    logic [IDX_W-1:0]    stack_top_reg, stack_top_next;
    logic                stack_empty_reg, stack_empty_next;
    logic [HW_W-1:0]     high_water_reg, high_water_next;
    logic                done_reg, done_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    status_t             status_reg, status_next;

    logic                mem_rd_en;
    logic [IDX_W-1:0]    mem_rd_addr;
    logic [ENTRY_W-1:0]  mem_rd_data;
    logic                mem_wr_en;
    logic [IDX_W-1:0]    mem_wr_addr;
    logic [ENTRY_W-1:0]  mem_wr_data;

    logic                rd_mark;
    logic                rd_end;
    logic [IDX_W-1:0]    rd_link;
    logic                req_in_range;

    fssa_mem #(
        .DEPTH (SLOT_LIMIT),
        .WIDTH (ENTRY_W)
    ) u_mem (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    assign rd_mark = mem_rd_data[ENTRY_W-1];
    assign rd_end  = mem_rd_data[IDX_W];
    assign rd_link = mem_rd_data[IDX_W-1:0];

    assign req_in_range = ({1'b0, req_reg} < CMP_W'(high_water_reg))
                       && ({1'b0, req_reg} < CMP_W'(SLOT_LIMIT));

    // read the entry a request needs as it is taken
    assign mem_rd_en   = (state_reg == S_IDLE) && start;
    assign mem_rd_addr = (kind == KIND_FREE) ? slot_to_free[IDX_W-1:0] : stack_top_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            stack_top_reg   <= '0;
            stack_empty_reg <= 1'b1;
            high_water_reg  <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            stack_top_reg   <= stack_top_next;
            stack_empty_reg <= stack_empty_next;
            high_water_reg  <= high_water_next;
            done_reg        <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        req_reg    <= req_next;
        slot_reg   <= slot_next;
        status_reg <= status_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        kind_next        = kind_reg;
        req_next         = req_reg;
        stack_top_next   = stack_top_reg;
        stack_empty_next = stack_empty_reg;
        high_water_next  = high_water_reg;
        done_next        = 1'b0;
        slot_next        = slot_reg;
        status_next      = status_reg;
        mem_wr_en        = 1'b0;
        mem_wr_addr      = stack_top_reg;
        mem_wr_data      = mem_rd_data;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    kind_next  = kind;
                    req_next   = slot_to_free;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                slot_next  = '0;
                if (kind_reg == KIND_ALLOC)
                begin
                    priority if (!stack_empty_reg)
                    begin
                        // pop: follow the link, mark the slot live again
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = stack_top_reg;
                        mem_wr_data = {1'b0, rd_end, rd_link};
                        slot_next   = SLOT_W'(stack_top_reg);
                        status_next = ST_REUSED;
                        if (rd_end)
                        begin
                            stack_empty_next = 1'b1;
                            stack_top_next   = '0;
                        end
                        else
                        begin
                            stack_top_next = rd_link;
                        end
                    end
                    else if (high_water_reg < HW_W'(SLOT_LIMIT))
                    begin
                        mem_wr_en       = 1'b1;
                        mem_wr_addr     = high_water_reg[IDX_W-1:0];
                        mem_wr_data     = {1'b0, 1'b1, {IDX_W{1'b0}}};
                        high_water_next = high_water_reg + 1'b1;
                        slot_next       = SLOT_W'(high_water_reg);
                        status_next     = ST_FRESH;
                    end
                    else
                    begin
                        status_next = ST_FULL;
                    end
                end
                else
                begin
                    if (req_in_range && !rd_mark)
                    begin
                        // push: old top becomes this slot's link
                        mem_wr_en        = 1'b1;
                        mem_wr_addr      = req_reg[IDX_W-1:0];
                        mem_wr_data      = {1'b1, stack_empty_reg, stack_top_reg};
                        stack_top_next   = req_reg[IDX_W-1:0];
                        stack_empty_next = 1'b0;
                        slot_next        = req_reg;
                        status_next      = ST_REUSED;
                    end
                    else
                    begin
                        status_next = ST_IGNORED;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy   = (state_reg == S_EXEC);
    assign done   = done_reg;
    assign slot   = slot_reg;
    assign status = status_reg;

    a_done_follows_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == S_EXEC))
        else $error("result strobe without a resolve cycle");

    a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && done_reg == 1'b0))
        else $error("accepted request did not enter resolve cycle");

    a_empty_top_zero: assert property (@(posedge clk) disable iff (!rst_n)
        stack_empty_reg |-> (stack_top_reg == '0))
        else $error("empty stack with non-zero top");

    a_hw_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        high_water_reg <= HW_W'(SLOT_LIMIT))
        else $error("high-water count beyond slot limit");

    a_fresh_bumps_hw: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg == ST_FRESH) |->
            (high_water_reg == $past(high_water_reg) + 1'b1 && high_water_reg != '0))
        else $error("fresh slot without high-water advance");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the free slot stack allocator core.
`timescale 1ns / 100ps

module tb_top;
    import fssa_pkg::*;

    localparam int SLOTS      = SLOT_CAP;
    localparam int USABLE     = (SLOTS < SLOT_CAP) ? SLOTS : SLOT_CAP;
    localparam int QUIET_MAX  = 500;
    localparam int DRAIN_WAIT = 8;

    typedef struct {
        logic              kind;
        logic [SLOT_W-1:0] slot;
        int unsigned       gap;
    } request_t;

    typedef struct {
        logic [SLOT_W-1:0] slot;
        status_t           status;
    } grant_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                kind = KIND_ALLOC;
    logic [SLOT_W-1:0]   slot_to_free = '0;
    logic                busy;
    logic                done;
    logic [SLOT_W-1:0]   slot;
    logic [STATUS_W-1:0] status;

    free_slot_stack_allocator_core #(
        .SLOT_COUNT (SLOTS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .slot_to_free (slot_to_free),
        .done         (done),
        .slot         (slot),
        .status       (status)
    );

    request_t    request_q[$];
    grant_t      pending_grants[$];
    request_t    next_req;
    grant_t      want;
    int unsigned idle_count = 0;
    int unsigned quiet_cycles = 0;
    int unsigned error_count = 0;

    // generator bookkeeping
    int unsigned alloc_issued = 0;
    int unsigned free_issued = 0;
    int unsigned queued_total = 0;
    int unsigned gap_style = 0;

    // shadow of the allocator
    logic [SLOT_W-1:0] free_head;
    logic              free_none;
    logic [SLOT_W:0]   fresh_next;
    logic [SLOT_W:0]   next_link [USABLE];
    logic              on_free_list [USABLE];

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic void clear_shadow();
        free_head  = '0;
        free_none  = 1'b1;
        fresh_next = '0;
        foreach (next_link[i]) next_link[i] = '0;
        foreach (on_free_list[i]) on_free_list[i] = 1'b0;
    endfunction

    function automatic grant_t resolve_request(logic req_kind, logic [SLOT_W-1:0] req_slot);
        grant_t g;
        g.slot   = '0;
        g.status = ST_FULL;
        if (req_kind == KIND_ALLOC)
        begin
            if (!free_none)
            begin
                g.slot   = free_head;
                g.status = ST_REUSED;
                // bit above the slot index marks the bottom of the free list
                if (next_link[free_head][SLOT_W])
                begin
                    free_none = 1'b1;
                    free_head = '0;
                end
                else
                begin
                    free_head = next_link[free_head][SLOT_W-1:0];
                end
                on_free_list[g.slot] = 1'b0;
            end
            else if (fresh_next < USABLE)
            begin
                g.slot   = fresh_next[SLOT_W-1:0];
                g.status = ST_FRESH;
                on_free_list[g.slot] = 1'b0;
                fresh_next = fresh_next + 1'b1;
            end
        end
        else if ({1'b0, req_slot} < fresh_next && !on_free_list[req_slot])
        begin
            next_link[req_slot]    = free_none ? {1'b1, {SLOT_W{1'b0}}} : {1'b0, free_head};
            on_free_list[req_slot] = 1'b1;
            free_head = req_slot;
            free_none = 1'b0;
            g.slot    = req_slot;
            g.status  = ST_REUSED;
        end
        else
        begin
            g.status = ST_IGNORED;
        end
        return g;
    endfunction

    function automatic void queue_request(logic req_kind, logic [SLOT_W-1:0] req_slot);
        request_t r;
        // idle pattern changes every few dozen requests, including runs with no gaps
        if (queued_total % 40 == 0)
            gap_style = $urandom_range(0, 2);
        r.kind = req_kind;
        r.slot = req_slot;
        case (gap_style)
            0:       r.gap = 0;
            1:       r.gap = $urandom_range(0, 14);
            default: r.gap = $urandom_range(0, 2);
        endcase
        request_q.push_back(r);
        queued_total++;
        if (req_kind == KIND_ALLOC)
            alloc_issued++;
        else
            free_issued++;
    endfunction

    function automatic logic [SLOT_W-1:0] pick_free_slot(int unsigned in_range_pct);
        int unsigned span;
        span = (alloc_issued < USABLE) ? alloc_issued : USABLE;
        if (span != 0 && $urandom_range(1, 100) <= in_range_pct)
            return SLOT_W'($urandom_range(0, span - 1));
        return SLOT_W'($urandom_range(0, 2**SLOT_W - 1));
    endfunction

    function automatic void random_request(int unsigned alloc_pct, int unsigned in_range_pct);
        if ($urandom_range(1, 100) <= alloc_pct)
            queue_request(KIND_ALLOC, SLOT_W'($urandom_range(0, 2**SLOT_W - 1)));
        else
            queue_request(KIND_FREE, pick_free_slot(in_range_pct));
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                pending_grants.push_back(resolve_request(kind, slot_to_free));
            if (!start || !busy)
            begin
                if (request_q.size() != 0 && idle_count >= request_q[0].gap)
                begin
                    next_req = request_q.pop_front();
                    start        <= 1'b1;
                    kind         <= next_req.kind;
                    slot_to_free <= next_req.slot;
                    idle_count   <= 0;
                end
                else
                begin
                    // junk on the fields while no request is offered
                    start        <= 1'b0;
                    kind         <= 1'($urandom_range(0, 1));
                    slot_to_free <= SLOT_W'($urandom_range(0, 2**SLOT_W - 1));
                    if (request_q.size() != 0)
                        idle_count <= idle_count + 1;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_grants.size() == 0)
            begin
                $error("unexpected result: slot %0d status %0d", slot, status);
                error_count++;
            end
            else
            begin
                want = pending_grants.pop_front();
                if (slot !== want.slot)
                begin
                    $error("slot: expected %0d, got %0d", want.slot, slot);
                    error_count++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles with neither a request nor a result taken
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_MAX)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        clear_shadow();

        // directed: ignored frees, fresh grants, linked pushes and pops
        queue_request(KIND_FREE, '0);
        queue_request(KIND_ALLOC, '1);
        queue_request(KIND_ALLOC, '0);
        queue_request(KIND_ALLOC, 10'h155);
        queue_request(KIND_FREE, '1);
        queue_request(KIND_FREE, 10'd1);
        queue_request(KIND_FREE, 10'd1);
        queue_request(KIND_FREE, 10'd0);
        queue_request(KIND_ALLOC, 10'h2aa);
        queue_request(KIND_ALLOC, '0);
        queue_request(KIND_ALLOC, '1);
        queue_request(KIND_FREE, 10'd2);
        queue_request(KIND_FREE, 10'd3);
        queue_request(KIND_FREE, 10'd0);
        queue_request(KIND_FREE, 10'd4);
        queue_request(KIND_ALLOC, '0);
        queue_request(KIND_ALLOC, '1);
        queue_request(KIND_ALLOC, '0);
        queue_request(KIND_ALLOC, '1);
        queue_request(KIND_FREE, 10'd2);

        // churn among the low slots
        repeat (60) random_request(50, 85);
        // fill until the fresh counter must have run out; the margin gives full results
        while (alloc_issued < free_issued + USABLE + 8)
            random_request(96, 90);
        // mixed traffic around the full mark, bias shifting every 20 requests
        repeat (6)
        begin
            automatic int unsigned bias = $urandom_range(20, 80);
            repeat (20) random_request(bias, 95);
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (request_q.size() != 0 || start || pending_grants.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);

        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
